FILE: sv/dhga_pkg.sv
// ============================================================================
// dhga_pkg
// Shared types, constants and helpers for the detection heat grid accumulator.
// ============================================================================
package dhga_pkg;

    localparam int COORD_W     = 5;
    localparam int CMD_W       = 2;
    localparam int TYPE_W      = 8;
    localparam int STR_W       = 8;
    localparam int VAL_W       = 16;
    localparam int MAXI_W      = 15;
    localparam int DECAY_W     = 16;
    localparam int SHARE_W     = 9;
    localparam int WEIGHT_W    = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MUL_W       = 24;
    localparam int PROD_W      = 2 * MUL_W;

    localparam int GRID_SIDE_DEF = 32;

    localparam logic [MAXI_W-1:0]  MAXI_RST  = 15'd1024;
    localparam logic [DECAY_W-1:0] DECAY_RST = 16'd62259;
    localparam logic [SHARE_W-1:0] SHARE_RST = 9'd77;

    // Reciprocal of 255 scaled by 2^31, exact for dividends below 2^24.
    localparam logic [MUL_W-1:0] RECIP_255 = 24'h808081;

    localparam logic [CMD_W-1:0] CMD_DETECT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DECAY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTENSITY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_SHARE = 2'd2;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    // Detection weight in Q1.8 for each class.
    function automatic logic [WEIGHT_W-1:0] weight_q88(input logic [TYPE_W-1:0] det_class);
        logic [WEIGHT_W-1:0] w;
        begin
            case (det_class)
                8'd1:    w = 9'd256;
                8'd2:    w = 9'd307;
                8'd3:    w = 9'd205;
                8'd4:    w = 9'd256;
                8'd5:    w = 9'd179;
                default: w = 9'd128;
            endcase
            return w;
        end
    endfunction

endpackage

FILE: sv/detection_heat_grid_accumulator.sv
// ============================================================================
// detection_heat_grid_accumulator
// Live and interval heat grids updated by detections, decay ticks and clears.
// ============================================================================
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_ready  | command, det_type, strength, grid_x, grid_y
//  out     | output    | out_valid / out_ready| live_value, interval_value, interval_count
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A detection runs sequencer steps S_M1 to S_M5 with the shared multiplier,
// then a read-modify-write sweep over every cell of both grids.
// A decay tick or a clear also sweeps every cell, and a read fetches one cell.
// After reset a clearing pass zeroes both memories and no input
// transaction is accepted meanwhile. A finished result waits in the
// output register, and the next one holds the block until it is taken.
// ============================================================================
module detection_heat_grid_accumulator #(
    parameter int GRID_SIDE = dhga_pkg::GRID_SIDE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dhga_pkg::CMD_W-1:0]        command,
    input  logic [dhga_pkg::TYPE_W-1:0]       det_type,
    input  logic [dhga_pkg::STR_W-1:0]        strength,
    input  logic [dhga_pkg::COORD_W-1:0]      grid_x,
    input  logic [dhga_pkg::COORD_W-1:0]      grid_y,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dhga_pkg::VAL_W-1:0]        live_value,
    output logic [dhga_pkg::VAL_W-1:0]        interval_value,
    output logic [dhga_pkg::VAL_W-1:0]        interval_count,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dhga_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dhga_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_SIDE);
    localparam int EW    = ((CW > dhga_pkg::COORD_W) ? CW : dhga_pkg::COORD_W) + 1;
    localparam int VW    = dhga_pkg::VAL_W;
    localparam int ADD_W = VW + 1;
    localparam int SUM_W = VW + 2;
    localparam int PW    = dhga_pkg::PROD_W;
    localparam int MW    = dhga_pkg::MUL_W;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_M1    = 4'd2;
    localparam logic [3:0] S_M2    = 4'd3;
    localparam logic [3:0] S_M3    = 4'd4;
    localparam logic [3:0] S_M4    = 4'd5;
    localparam logic [3:0] S_M5    = 4'd6;
    localparam logic [3:0] S_SWEEP = 4'd7;
    localparam logic [3:0] S_DRAIN = 4'd8;
    localparam logic [3:0] S_RD    = 4'd9;
    localparam logic [3:0] S_RDW   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    localparam logic [1:0] MODE_INIT   = 2'd0;
    localparam logic [1:0] MODE_DETECT = 2'd1;
    localparam logic [1:0] MODE_DECAY  = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    logic [3:0]   state_reg, state_next;
    logic [1:0]   mode_reg;

    logic [dhga_pkg::MAXI_W-1:0]  max_int_reg;
    logic [dhga_pkg::DECAY_W-1:0] decay_reg;
    logic [dhga_pkg::SHARE_W-1:0] share_cfg_reg;
    logic [VW-1:0]                clear_cnt_reg;

    logic [dhga_pkg::TYPE_W-1:0]  type_reg;
    logic [dhga_pkg::STR_W-1:0]   str_reg;
    logic [dhga_pkg::COORD_W-1:0] x_reg;
    logic [dhga_pkg::COORD_W-1:0] y_reg;
    logic [VW-1:0]                inten_reg;
    logic [ADD_W-1:0]             share_reg;

    logic [AW-1:0]    addr_cnt_reg;
    logic [CW-1:0]    cx_reg;
    logic [CW-1:0]    cy_reg;
    logic             s1_valid_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic [ADD_W-1:0] s1_add_reg;
    logic             s2_valid_reg;
    logic [AW-1:0]    s2_addr_reg;
    logic [VW-1:0]    s2_live_reg;
    logic [VW-1:0]    s2_intv_reg;

    logic [VW-1:0]    res_live_reg;
    logic [VW-1:0]    res_intv_reg;
    logic             out_valid_reg;
    logic [VW-1:0]    out_live_reg;
    logic [VW-1:0]    out_intv_reg;
    logic [VW-1:0]    out_cnt_reg;

    logic             in_fire;
    logic             in_grid_in;
    logic             out_load;
    logic [VW-1:0]    cap;
    logic [EW-1:0]    xe, ye, cxe, cye;
    logic             near_x, near_y, center;
    logic [ADD_W-1:0] add0;
    logic [31:0]      rd_addr_full;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    raddr;
    logic [SUM_W-1:0] sum_live, sum_intv;
    logic [VW-1:0]    clamp_live, clamp_intv;
    logic             live_we, intv_we;
    logic [VW-1:0]    live_wdata, intv_wdata;
    logic [VW-1:0]    live_rdata, intv_rdata;

    dhga_pkg::mul_req_t  mul_req;
    logic [PW-1:0]       prod;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign cap       = {max_int_reg, 1'b0};

    assign in_grid_in = (EW'(grid_x) < EW'(GRID_SIDE)) && (EW'(grid_y) < EW'(GRID_SIDE));

    assign xe  = EW'(x_reg);
    assign ye  = EW'(y_reg);
    assign cxe = EW'(cx_reg);
    assign cye = EW'(cy_reg);

    assign near_x = (cxe == xe) || (cxe + EW'(1) == xe) || (cxe == xe + EW'(1));
    assign near_y = (cye == ye) || (cye + EW'(1) == ye) || (cye == ye + EW'(1));
    assign center = (cxe == xe) && (cye == ye);

    always_comb
    begin
        if (center)
        begin
            add0 = ADD_W'(inten_reg);
        end
        else if (near_x && near_y)
        begin
            add0 = share_reg;
        end
        else
        begin
            add0 = '0;
        end
    end

    assign rd_addr_full = 32'(y_reg) * 32'(GRID_SIDE) + 32'(x_reg);
    assign rd_addr      = rd_addr_full[AW-1:0];
    assign raddr        = (state_reg == S_RD) ? rd_addr : addr_cnt_reg;

    assign sum_live   = SUM_W'(live_rdata) + SUM_W'(s1_add_reg);
    assign sum_intv   = SUM_W'(intv_rdata) + SUM_W'(s1_add_reg);
    assign clamp_live = (sum_live > SUM_W'(cap)) ? cap : sum_live[VW-1:0];
    assign clamp_intv = (sum_intv > SUM_W'(cap)) ? cap : sum_intv[VW-1:0];

    always_comb
    begin
        case (state_reg)
            S_M1:
            begin
                mul_req.a = MW'(str_reg);
                mul_req.b = MW'(max_int_reg);
            end
            S_M2:
            begin
                mul_req.a = prod[MW-1:0];
                mul_req.b = MW'(dhga_pkg::weight_q88(type_reg));
            end
            S_M3:
            begin
                mul_req.a = prod[MW+7:8];
                mul_req.b = dhga_pkg::RECIP_255;
            end
            S_M4:
            begin
                mul_req.a = MW'(prod[VW+30:31]);
                mul_req.b = MW'(share_cfg_reg);
            end
            default:
            begin
                mul_req.a = MW'(live_rdata);
                mul_req.b = MW'(decay_reg);
            end
        endcase
    end

    dhga_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    always_comb
    begin
        live_we    = 1'b0;
        intv_we    = 1'b0;
        live_wdata = '0;
        intv_wdata = '0;
        case (mode_reg)
            MODE_INIT:
            begin
                live_we = s2_valid_reg;
                intv_we = s2_valid_reg;
            end
            MODE_DETECT:
            begin
                live_we    = s2_valid_reg;
                intv_we    = s2_valid_reg;
                live_wdata = s2_live_reg;
                intv_wdata = s2_intv_reg;
            end
            MODE_DECAY:
            begin
                live_we    = s2_valid_reg;
                live_wdata = prod[2*VW-1:VW];
            end
            MODE_CLEAR:
            begin
                intv_we = s2_valid_reg;
            end
            default:
            begin
                live_we = 1'b0;
            end
        endcase
    end

    dhga_ram #(
        .WIDTH (VW),
        .DEPTH (CELLS)
    ) u_live_ram (
        .clk   (clk),
        .we    (live_we),
        .waddr (s2_addr_reg),
        .wdata (live_wdata),
        .raddr (raddr),
        .rdata (live_rdata)
    );

    dhga_ram #(
        .WIDTH (VW),
        .DEPTH (CELLS)
    ) u_intv_ram (
        .clk   (clk),
        .we    (intv_we),
        .waddr (s2_addr_reg),
        .wdata (intv_wdata),
        .raddr (raddr),
        .rdata (intv_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                state_next = S_SWEEP;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (command)
                        dhga_pkg::CMD_DETECT: state_next = in_grid_in ? S_M1 : S_FIN;
                        dhga_pkg::CMD_DECAY:  state_next = S_SWEEP;
                        dhga_pkg::CMD_CLEAR:  state_next = S_SWEEP;
                        dhga_pkg::CMD_READ:   state_next = in_grid_in ? S_RD : S_FIN;
                        default:              state_next = S_FIN;
                    endcase
                end
            end
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_M4;
            S_M4:    state_next = S_M5;
            S_M5:    state_next = S_SWEEP;
            S_SWEEP:
            begin
                if (addr_cnt_reg == AW'(CELLS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = (mode_reg == MODE_INIT) ? S_IDLE : S_FIN;
                end
            end
            S_RD:    state_next = S_RDW;
            S_RDW:   state_next = S_FIN;
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            mode_reg      <= MODE_INIT;
            addr_cnt_reg  <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            clear_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            max_int_reg   <= dhga_pkg::MAXI_RST;
            decay_reg     <= dhga_pkg::DECAY_RST;
            share_cfg_reg <= dhga_pkg::SHARE_RST;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= (state_reg == S_SWEEP);
            s2_valid_reg <= s1_valid_reg;

            if (cfg_valid)
            begin
                case (cfg_index)
                    dhga_pkg::CFG_MAX_INTENSITY:  max_int_reg   <= cfg_data[dhga_pkg::MAXI_W-1:0];
                    dhga_pkg::CFG_DECAY_FACTOR:   decay_reg     <= cfg_data[dhga_pkg::DECAY_W-1:0];
                    dhga_pkg::CFG_NEIGHBOR_SHARE: share_cfg_reg <= cfg_data[dhga_pkg::SHARE_W-1:0];
                    default:                      decay_reg     <= decay_reg;
                endcase
            end

            if (in_fire)
            begin
                addr_cnt_reg <= '0;
                cx_reg       <= '0;
                cy_reg       <= '0;
                case (command)
                    dhga_pkg::CMD_DETECT: mode_reg <= MODE_DETECT;
                    dhga_pkg::CMD_DECAY:  mode_reg <= MODE_DECAY;
                    dhga_pkg::CMD_CLEAR:
                    begin
                        mode_reg      <= MODE_CLEAR;
                        clear_cnt_reg <= clear_cnt_reg + VW'(1);
                    end
                    default:              mode_reg <= MODE_DETECT;
                endcase
            end
            else if (state_reg == S_SWEEP)
            begin
                addr_cnt_reg <= addr_cnt_reg + AW'(1);
                if (cx_reg == CW'(GRID_SIDE - 1))
                begin
                    cx_reg <= '0;
                    cy_reg <= cy_reg + CW'(1);
                end
                else
                begin
                    cx_reg <= cx_reg + CW'(1);
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            type_reg     <= det_type;
            str_reg      <= strength;
            x_reg        <= grid_x;
            y_reg        <= grid_y;
            res_live_reg <= '0;
            res_intv_reg <= '0;
        end
        if (state_reg == S_RDW)
        begin
            res_live_reg <= live_rdata;
            res_intv_reg <= intv_rdata;
        end
        if (state_reg == S_M4)
        begin
            inten_reg <= prod[VW+30:31];
        end
        if (state_reg == S_M5)
        begin
            share_reg <= prod[ADD_W+7:8];
        end

        s1_addr_reg <= addr_cnt_reg;
        s1_add_reg  <= (mode_reg == MODE_DETECT) ? add0 : '0;
        s2_addr_reg <= s1_addr_reg;
        s2_live_reg <= clamp_live;
        s2_intv_reg <= clamp_intv;

        if (out_load)
        begin
            out_live_reg <= res_live_reg;
            out_intv_reg <= res_intv_reg;
            out_cnt_reg  <= clear_cnt_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign live_value     = out_live_reg;
    assign interval_value = out_intv_reg;
    assign interval_count = out_cnt_reg;

endmodule

FILE: sv/dhga_ram.sv
// ============================================================================
// dhga_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
module dhga_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/dhga_mul.sv
// ============================================================================
// dhga_mul
// Shared multiplier with a registered product, time-shared by the sequencer.
// ============================================================================
module dhga_mul (
    input  logic                           clk,
    input  dhga_pkg::mul_req_t             req,
    output logic [dhga_pkg::PROD_W-1:0]    prod
);

    logic [dhga_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= dhga_pkg::PROD_W'(req.a) * dhga_pkg::PROD_W'(req.b);
    end

    assign prod = prod_reg;

endmodule
